FILE: hw/rtl/qn_pkg.sv
// qn_pkg: shared constants for the quaternion normalizer.
// No dependencies; used by the interfaces, the arithmetic units and the top level.
package qn_pkg;

  // Default component width (signed Q1.F with F = width - 2).
  localparam int unsigned COMP_WIDTH_DEF = 16;
  // Quaternion has four components, handled as four parallel lanes.
  localparam int unsigned NUM_LANES      = 4;
  // Magnitudes are left-aligned into this width before the unit divide.
  localparam int unsigned SCALE_W        = 32;
  // Leading one of the largest aligned magnitude lands at this bit.
  localparam int unsigned SCALE_TOP      = 30;
  localparam int unsigned SHIFT_W        = $clog2(SCALE_W);
  // Radicand and root widths of the square root units.
  localparam int unsigned SQRT_RAD_W     = 2 * SCALE_W + 2;
  localparam int unsigned SQRT_ROOT_W    = SQRT_RAD_W / 2;

endpackage

FILE: hw/rtl/qn_if.sv
// qn_if: valid/ready channel interfaces for quaternion input and normalized output.
// Depends on qn_pkg for the default component width.
interface qn_in_if
  import qn_pkg::*;
#(
  parameter int unsigned W = COMP_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] q_w;
  logic signed [W-1:0] q_x;
  logic signed [W-1:0] q_y;
  logic signed [W-1:0] q_z;

  modport source (output valid, q_w, q_x, q_y, q_z, input ready);
  modport sink   (input valid, q_w, q_x, q_y, q_z, output ready);
endinterface

interface qn_out_if
  import qn_pkg::*;
#(
  parameter int unsigned W = COMP_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] unit_w;
  logic signed [W-1:0] unit_x;
  logic signed [W-1:0] unit_y;
  logic signed [W-1:0] unit_z;
  logic        [W-1:0] magnitude;
  logic                zero_input;

  modport source (output valid, unit_w, unit_x, unit_y, unit_z, magnitude, zero_input,
                  input ready);
  modport sink   (input valid, unit_w, unit_x, unit_y, unit_z, magnitude, zero_input,
                  output ready);
endinterface

FILE: hw/rtl/qn_isqrt.sv
// qn_isqrt: pipelined digit-by-digit integer square root, one root bit per stage.
// Depends on qn_pkg for default widths; stage enables come from the top level.
module qn_isqrt
  import qn_pkg::*;
#(
  parameter int unsigned RAD_W  = SQRT_RAD_W,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                 clk_i,
  input  logic [RAD_W/2-1:0]   load_i,
  input  logic [RAD_W-1:0]     rad_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic [RAD_W/2-1:0]   root_o,
  output logic [RAD_W/2+1:0]   rem_o,
  output logic [SIDE_W-1:0]    side_o
);

  localparam int unsigned RW = RAD_W / 2;  // root bits, one per stage
  localparam int unsigned PW = RW + 2;     // partial remainder bits

  logic [PW-1:0]     rem_q  [RW];
  logic [RW-1:0]     root_q [RW];
  logic [RAD_W-1:0]  rad_q  [RW];
  logic [SIDE_W-1:0] side_q [RW];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic [PW-1:0]     rem_in;
    logic [PW-1:0]     rem_sh;
    logic [PW-1:0]     trial;
    logic [RW-1:0]     root_in;
    logic [RAD_W-1:0]  rad_in;
    logic [SIDE_W-1:0] side_in;
    logic              fit;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
      assign side_in = side_q[s-1];
    end

    // remainder is at most 2*root, so its top two bits are free here
    assign rem_sh = {rem_in[PW-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign fit    = (rem_sh >= trial);

    always_ff @(posedge clk_i) begin
      if (load_i[s]) begin
        rem_q[s]  <= fit ? (rem_sh - trial) : rem_sh;
        root_q[s] <= {root_in[RW-2:0], fit};
        rad_q[s]  <= rad_in << 2;
        side_q[s] <= side_in;
      end
    end
  end

  assign root_o = root_q[RW-1];
  assign rem_o  = rem_q[RW-1];
  assign side_o = side_q[RW-1];

endmodule

FILE: hw/rtl/qn_div.sv
// qn_div: pipelined restoring divider, four lanes sharing one divisor, one quotient
// bit per stage. Depends on qn_pkg; stage enables come from the top level.
module qn_div
  import qn_pkg::*;
#(
  parameter int unsigned QUO_W  = COMP_WIDTH_DEF - 1,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                                    clk_i,
  input  logic [QUO_W-1:0]                        load_i,
  input  logic [SQRT_ROOT_W-1:0]                  dvs_i,
  input  logic [NUM_LANES-1:0][SQRT_ROOT_W-1:0]   part_i,
  input  logic [NUM_LANES-1:0][QUO_W-1:0]         low_i,
  input  logic [SIDE_W-1:0]                       side_i,
  output logic [NUM_LANES-1:0][QUO_W-1:0]         quo_o,
  output logic [SIDE_W-1:0]                       side_o
);

  localparam int unsigned DV = SQRT_ROOT_W;

  // part: running remainder, always below the divisor
  // bits: dividend bits shift out at the top, quotient bits shift in below
  logic [NUM_LANES-1:0][DV-1:0]    part_q [QUO_W];
  logic [NUM_LANES-1:0][QUO_W-1:0] bits_q [QUO_W];
  logic [DV-1:0]                   dvs_q  [QUO_W];
  logic [SIDE_W-1:0]               side_q [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic [NUM_LANES-1:0][DV-1:0]    part_in;
    logic [NUM_LANES-1:0][DV-1:0]    part_nx;
    logic [NUM_LANES-1:0][QUO_W-1:0] bits_in;
    logic [NUM_LANES-1:0][QUO_W-1:0] bits_nx;
    logic [DV-1:0]                   dvs_in;
    logic [SIDE_W-1:0]               side_in;

    if (s == 0) begin : g_first
      assign part_in = part_i;
      assign bits_in = low_i;
      assign dvs_in  = dvs_i;
      assign side_in = side_i;
    end else begin : g_next
      assign part_in = part_q[s-1];
      assign bits_in = bits_q[s-1];
      assign dvs_in  = dvs_q[s-1];
      assign side_in = side_q[s-1];
    end

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      logic [DV:0] trial;
      logic [DV:0] diff;
      logic        fit;

      assign trial = {part_in[l], bits_in[l][QUO_W-1]};
      assign diff  = trial - {1'b0, dvs_in};
      assign fit   = (trial >= {1'b0, dvs_in});
      assign part_nx[l] = fit ? diff[DV-1:0] : trial[DV-1:0];
      assign bits_nx[l] = {bits_in[l][QUO_W-2:0], fit};
    end

    always_ff @(posedge clk_i) begin
      if (load_i[s]) begin
        part_q[s] <= part_nx;
        bits_q[s] <= bits_nx;
        dvs_q[s]  <= dvs_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign quo_o  = bits_q[QUO_W-1];
  assign side_o = side_q[QUO_W-1];

endmodule

FILE: hw/rtl/quaternion_normalize.sv
// quaternion_normalize: top level of the fixed-point quaternion normalizer.
// Depends on qn_pkg, qn_in_if / qn_out_if, qn_isqrt and qn_div.
//
// Takes one quaternion (w, x, y, z) of signed Q1.F components (F = COMPONENT_WIDTH - 2)
// per transaction and returns its Euclidean norm as unsigned Q2.F, rounded to nearest
// and saturated to all ones, together with the unit quaternion in signed Q1.F, each
// component rounded to nearest and within [-1.0, +1.0]. An all-zero quaternion sets
// zero_input and returns zero components and zero magnitude. A new transaction is
// accepted every cycle while the pipeline has room; the result passes through the
// 33-stage square root (one root bit per stage) and the F+1 stage divider (one
// quotient bit per stage). Nothing is kept between transactions. Backpressure is
// absorbed stage by stage: while the output waits, the input stays ready until the
// pipeline holds no empty slot, so no transaction is dropped or repeated.
//
// Pipeline stages:
//   0        absolute values, signs, zero detect
//   1        largest magnitude; squares for the norm
//   2        alignment shift count; pairwise norm sums
//   3        aligned magnitudes; norm sum of squares
//   4..6     squares of aligned magnitudes, pairwise and total sum
//   7..39    two square roots in lockstep (aligned sum and norm sum)
//   40       round both roots; saturate the norm
//   41       dividend = aligned * 2^F + root/2, split for the divider
//   42..42+F quotient bits, four lanes
//   43+F     clamp, sign, zero override -> output register
module quaternion_normalize
  import qn_pkg::*;
#(
  parameter int unsigned COMPONENT_WIDTH = COMP_WIDTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  qn_in_if.sink    in_i,
  qn_out_if.source out_o
);

  localparam int unsigned W       = COMPONENT_WIDTH;
  localparam int unsigned F       = W - 2;
  localparam int unsigned QW      = F + 1;              // quotient bits
  localparam int unsigned NSQ_W   = 2 * W;
  localparam int unsigned NPR_W   = 2 * W + 1;
  localparam int unsigned NSUM_W  = 2 * W + 2;
  localparam int unsigned SSQ_W   = 2 * SCALE_W;
  localparam int unsigned SPR_W   = 2 * SCALE_W + 1;
  localparam int unsigned RT_W    = SQRT_ROOT_W;
  localparam int unsigned REM_W   = SQRT_ROOT_W + 2;
  localparam int unsigned DW      = SCALE_W + QW;       // dividend bits
  localparam int          UnitOne = 1 << F;

  localparam int unsigned ST_ABS   = 0;
  localparam int unsigned ST_MAX   = 1;
  localparam int unsigned ST_SHIFT = 2;
  localparam int unsigned ST_SCALE = 3;
  localparam int unsigned ST_SSQ   = 4;
  localparam int unsigned ST_SPAIR = 5;
  localparam int unsigned ST_SSUM  = 6;
  localparam int unsigned ST_ROOT  = 7;
  localparam int unsigned ST_RND   = ST_ROOT + RT_W;
  localparam int unsigned ST_DVD   = ST_RND + 1;
  localparam int unsigned ST_DIV   = ST_DVD + 1;
  localparam int unsigned ST_OUT   = ST_DIV + QW;
  localparam int unsigned NSTG     = ST_OUT + 1;

  typedef struct packed {
    logic                              zero;
    logic [NUM_LANES-1:0][SCALE_W-1:0] scl;
  } root_side_t;

  typedef struct packed {
    logic                 zero;
    logic [NUM_LANES-1:0] neg;
    logic [W-1:0]         norm;
  } div_side_t;

  // ---------------------------------------------------------------------------
  // Flow control: a stage loads when the output drains or an empty slot lies
  // at or after it, so bubbles collapse under backpressure.
  // ---------------------------------------------------------------------------
  logic [NSTG-1:0] valid_q;
  logic [NSTG-1:0] valid_d;
  logic [NSTG-1:0] load;

  for (genvar g = 0; g < NSTG; g++) begin : g_load
    assign load[g] = out_o.ready | ~(&valid_q[NSTG-1:g]);
  end

  assign valid_d = {valid_q[NSTG-2:0], in_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= (valid_d & load) | (valid_q & ~load);
    end
  end

  assign in_i.ready  = load[ST_ABS];
  assign out_o.valid = valid_q[ST_OUT];

  // ---------------------------------------------------------------------------
  // Stage 0: sign split. The most negative code maps to its true magnitude.
  // ---------------------------------------------------------------------------
  logic [NUM_LANES-1:0][W-1:0] comp;
  logic [NUM_LANES-1:0][W-1:0] mag0_d, mag0_q;
  logic [NUM_LANES-1:0]        neg0_d, neg0_q;
  logic                        zero0_q;

  assign comp[0] = in_i.q_w;
  assign comp[1] = in_i.q_x;
  assign comp[2] = in_i.q_y;
  assign comp[3] = in_i.q_z;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      neg0_d[l] = comp[l][W-1];
      mag0_d[l] = neg0_d[l] ? (~comp[l] + W'(1)) : comp[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[ST_ABS]) begin
      mag0_q  <= mag0_d;
      neg0_q  <= neg0_d;
      zero0_q <= (comp == '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: largest magnitude, norm squares
  // ---------------------------------------------------------------------------
  logic [W-1:0]                    m01, m23;
  logic [W-1:0]                    max1_q;
  logic [NUM_LANES-1:0][NSQ_W-1:0] nsq1_d, nsq1_q;
  logic [NUM_LANES-1:0][W-1:0]     mag1_q;
  logic [NUM_LANES-1:0]            neg1_q;
  logic                            zero1_q;

  assign m01 = (mag0_q[0] > mag0_q[1]) ? mag0_q[0] : mag0_q[1];
  assign m23 = (mag0_q[2] > mag0_q[3]) ? mag0_q[2] : mag0_q[3];

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      nsq1_d[l] = mag0_q[l] * mag0_q[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[ST_MAX]) begin
      max1_q  <= (m01 > m23) ? m01 : m23;
      nsq1_q  <= nsq1_d;
      mag1_q  <= mag0_q;
      neg1_q  <= neg0_q;
      zero1_q <= zero0_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: shift that puts the largest magnitude's leading one at SCALE_TOP
  // ---------------------------------------------------------------------------
  logic [SCALE_W-1:0]          max_ext;
  logic [SHIFT_W-1:0]          msb;
  logic [SHIFT_W-1:0]          sh2_d, sh2_q;
  logic [1:0][NPR_W-1:0]       npair2_q;
  logic [NUM_LANES-1:0][W-1:0] mag2_q;
  logic [NUM_LANES-1:0]        neg2_q;
  logic                        zero2_q;

  assign max_ext = SCALE_W'(max1_q);

  always_comb begin
    msb = '0;
    for (int b = 0; b < SCALE_W; b++) begin
      if (max_ext[b]) begin
        msb = SHIFT_W'(b);
      end
    end
  end

  assign sh2_d = (msb >= SHIFT_W'(SCALE_TOP)) ? '0 : (SHIFT_W'(SCALE_TOP) - msb);

  always_ff @(posedge clk_i) begin
    if (load[ST_SHIFT]) begin
      sh2_q       <= sh2_d;
      npair2_q[0] <= NPR_W'(nsq1_q[0]) + NPR_W'(nsq1_q[1]);
      npair2_q[1] <= NPR_W'(nsq1_q[2]) + NPR_W'(nsq1_q[3]);
      mag2_q      <= mag1_q;
      neg2_q      <= neg1_q;
      zero2_q     <= zero1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: aligned magnitudes, norm sum of squares
  // ---------------------------------------------------------------------------
  logic [NUM_LANES-1:0][SCALE_W-1:0] scl3_d, scl3_q;
  logic [NSUM_W-1:0]                 nsum3_q;
  logic [NUM_LANES-1:0]              neg3_q;
  logic                              zero3_q;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      scl3_d[l] = SCALE_W'(mag2_q[l]) << sh2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[ST_SCALE]) begin
      scl3_q  <= scl3_d;
      nsum3_q <= NSUM_W'(npair2_q[0]) + NSUM_W'(npair2_q[1]);
      neg3_q  <= neg2_q;
      zero3_q <= zero2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 4..6: sum of squares of the aligned magnitudes
  // ---------------------------------------------------------------------------
  logic [NUM_LANES-1:0][SSQ_W-1:0]   ssq4_d, ssq4_q;
  logic [NUM_LANES-1:0][SCALE_W-1:0] scl4_q, scl5_q, scl6_q;
  logic [NSUM_W-1:0]                 nsum4_q, nsum5_q, nsum6_q;
  logic [NUM_LANES-1:0]              neg4_q, neg5_q, neg6_q;
  logic                              zero4_q, zero5_q, zero6_q;
  logic [1:0][SPR_W-1:0]             spair5_q;
  logic [SQRT_RAD_W-1:0]             ssum6_q;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      ssq4_d[l] = scl3_q[l] * scl3_q[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[ST_SSQ]) begin
      ssq4_q  <= ssq4_d;
      scl4_q  <= scl3_q;
      nsum4_q <= nsum3_q;
      neg4_q  <= neg3_q;
      zero4_q <= zero3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[ST_SPAIR]) begin
      spair5_q[0] <= SPR_W'(ssq4_q[0]) + SPR_W'(ssq4_q[1]);
      spair5_q[1] <= SPR_W'(ssq4_q[2]) + SPR_W'(ssq4_q[3]);
      scl5_q      <= scl4_q;
      nsum5_q     <= nsum4_q;
      neg5_q      <= neg4_q;
      zero5_q     <= zero4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[ST_SSUM]) begin
      ssum6_q <= SQRT_RAD_W'(spair5_q[0]) + SQRT_RAD_W'(spair5_q[1]);
      scl6_q  <= scl5_q;
      nsum6_q <= nsum5_q;
      neg6_q  <= neg5_q;
      zero6_q <= zero5_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 7..39: both roots in lockstep, so the norm needs no realignment
  // ---------------------------------------------------------------------------
  root_side_t           rside_in, rside_out;
  logic [RT_W-1:0]      sroot, nroot;
  logic [REM_W-1:0]     srem, nrem;
  logic [NUM_LANES-1:0] neg_rt;

  assign rside_in.zero = zero6_q;
  assign rside_in.scl  = scl6_q;

  qn_isqrt #(
    .RAD_W  (SQRT_RAD_W),
    .SIDE_W ($bits(root_side_t))
  ) u_sqrt_unit (
    .clk_i  (clk_i),
    .load_i (load[ST_ROOT +: RT_W]),
    .rad_i  (ssum6_q),
    .side_i (rside_in),
    .root_o (sroot),
    .rem_o  (srem),
    .side_o (rside_out)
  );

  qn_isqrt #(
    .RAD_W  (SQRT_RAD_W),
    .SIDE_W (NUM_LANES)
  ) u_sqrt_norm (
    .clk_i  (clk_i),
    .load_i (load[ST_ROOT +: RT_W]),
    .rad_i  (SQRT_RAD_W'(nsum6_q)),
    .side_i (neg6_q),
    .root_o (nroot),
    .rem_o  (nrem),
    .side_o (neg_rt)
  );

  // ---------------------------------------------------------------------------
  // Stage 40: round to nearest (remainder above root means the upper half)
  // ---------------------------------------------------------------------------
  logic [RT_W-1:0]                   r_rnd, n_rnd;
  logic [RT_W-1:0]                   r40_q;
  logic [W-1:0]                      norm40_q;
  logic [NUM_LANES-1:0][SCALE_W-1:0] scl40_q;
  logic [NUM_LANES-1:0]              neg40_q;
  logic                              zero40_q;

  assign r_rnd = sroot + RT_W'(srem > {2'b00, sroot});
  assign n_rnd = nroot + RT_W'(nrem > {2'b00, nroot});

  always_ff @(posedge clk_i) begin
    if (load[ST_RND]) begin
      r40_q    <= r_rnd;
      norm40_q <= ((n_rnd >> W) != '0) ? {W{1'b1}} : n_rnd[W-1:0];
      scl40_q  <= rside_out.scl;
      neg40_q  <= neg_rt;
      zero40_q <= rside_out.zero;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 41: dividend, split into the opening partial remainder (already
  // below the divisor, since no unit exceeds 2^F) and the bits still to bring in
  // ---------------------------------------------------------------------------
  logic [NUM_LANES-1:0][DW-1:0]   dfull;
  logic [NUM_LANES-1:0][RT_W-1:0] dpart41_q;
  logic [NUM_LANES-1:0][QW-1:0]   dlow41_q;
  logic [RT_W-1:0]                r41_q;
  div_side_t                      dside41_q;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      dfull[l] = (DW'(scl40_q[l]) << F) + DW'(r40_q >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[ST_DVD]) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        dpart41_q[l] <= RT_W'(dfull[l][DW-1:QW]);
        dlow41_q[l]  <= dfull[l][QW-1:0];
      end
      r41_q          <= r40_q;
      dside41_q.zero <= zero40_q;
      dside41_q.neg  <= neg40_q;
      dside41_q.norm <= norm40_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 42..42+F: unit quotients
  // ---------------------------------------------------------------------------
  logic [NUM_LANES-1:0][QW-1:0] quo;
  div_side_t                    dside_out;

  qn_div #(
    .QUO_W  (QW),
    .SIDE_W ($bits(div_side_t))
  ) u_div (
    .clk_i  (clk_i),
    .load_i (load[ST_DIV +: QW]),
    .dvs_i  (r41_q),
    .part_i (dpart41_q),
    .low_i  (dlow41_q),
    .side_i (dside41_q),
    .quo_o  (quo),
    .side_o (dside_out)
  );

  // ---------------------------------------------------------------------------
  // Output stage: clamp to 1.0, restore sign, zero quaternion override
  // ---------------------------------------------------------------------------
  logic [QW-1:0]                      one_q1;
  logic [NUM_LANES-1:0][QW-1:0]       u_clamp;
  logic [NUM_LANES-1:0][W-1:0]        unit_d;
  logic [NUM_LANES-1:0][W-1:0]        unit_q;
  logic [W-1:0]                       magn_q;
  logic                               zflag_q;

  assign one_q1 = QW'(1) << F;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      u_clamp[l] = (quo[l] > one_q1) ? one_q1 : quo[l];
      if (dside_out.zero) begin
        unit_d[l] = '0;
      end else if (dside_out.neg[l]) begin
        unit_d[l] = -{1'b0, u_clamp[l]};
      end else begin
        unit_d[l] = {1'b0, u_clamp[l]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[ST_OUT]) begin
      unit_q  <= unit_d;
      magn_q  <= dside_out.zero ? '0 : dside_out.norm;
      zflag_q <= dside_out.zero;
    end
  end

  assign out_o.unit_w     = unit_q[0];
  assign out_o.unit_x     = unit_q[1];
  assign out_o.unit_y     = unit_q[2];
  assign out_o.unit_z     = unit_q[3];
  assign out_o.magnitude  = magn_q;
  assign out_o.zero_input = zflag_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // zero quaternion gives an all-zero result
  a_zero_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.zero_input |->
      out_o.unit_w == '0 && out_o.unit_x == '0 && out_o.unit_y == '0 &&
      out_o.unit_z == '0 && out_o.magnitude == '0)
    else $error("zero quaternion produced a nonzero result");

  // any nonzero quaternion has a nonzero norm and a nonzero unit part
  a_nonzero_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.zero_input |->
      out_o.magnitude != '0 &&
      (out_o.unit_w | out_o.unit_x | out_o.unit_y | out_o.unit_z) != '0)
    else $error("nonzero quaternion produced a degenerate result");

  // unit components stay within [-1.0, +1.0]
  a_unit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |->
      int'(out_o.unit_w) <= UnitOne && int'(out_o.unit_w) >= -UnitOne &&
      int'(out_o.unit_x) <= UnitOne && int'(out_o.unit_x) >= -UnitOne &&
      int'(out_o.unit_y) <= UnitOne && int'(out_o.unit_y) >= -UnitOne &&
      int'(out_o.unit_z) <= UnitOne && int'(out_o.unit_z) >= -UnitOne)
    else $error("unit component beyond 1.0");

endmodule
